// ===== rtl/lrs_pkg.sv =====
// Shared package for the linear 48 kHz stereo resampler.
// Holds widths, rate constants, register indexes and the payload/control structs.
// No dependencies.
`timescale 1ns / 1ps

package lrs_pkg;

  // Sample and rate widths
  localparam int SAMPLE_W    = 24;
  localparam int OUT_RATE    = 48000;
  localparam int HALF_RATE   = OUT_RATE / 2;
  localparam int RATE_MIN    = 8000;
  localparam int RATE_MAX    = 192000;
  localparam int RATE_RESET  = 48000;
  localparam int MAX_RESULTS = 16;

  localparam int RATE_W     = 18;
  localparam int CH_W       = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = RATE_W;

  // Sequencer state widths
  localparam int PH_W   = 18;  // running phase, holds up to 48000 + max rate
  localparam int TAIL_W = 22;  // signed tail margin kept between frames
  localparam int M_W    = 24;  // signed margin while generating
  localparam int CNT_W  = 5;   // outputs per frame, 0..16
  localparam int PHS_W  = 16;  // phase handed to the lanes, 0..48000

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(1);

  // Channel count codes
  localparam logic [CH_W-1:0] CH_MONO   = CH_W'(1);
  localparam logic [CH_W-1:0] CH_STEREO = CH_W'(2);

  // Lane arithmetic: round(mag*p/48000) via reciprocal multiply plus correction.
  // 48000 = 375 << 7; the estimate uses the top YH_W bits of mag*p + 24000.
  localparam int D_W    = SAMPLE_W + 1;
  localparam int X_W    = SAMPLE_W + PHS_W;
  localparam int YH_W   = D_W;
  localparam int YH_SH  = X_W - YH_W;
  localparam int DIV_SH = 7;
  localparam int DIV_K  = OUT_RATE / (1 << DIV_SH);
  localparam longint RECIP = (longint'(1) << (YH_SH - DIV_SH + YH_W)) / DIV_K;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic                       in_last;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       out_last;
  } out_t;

  // Issue slot from sequencer to both lanes
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [PHS_W-1:0] phase;
  } iss_t;

  // Endpoints of one channel's interpolation
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
  } lane_req_t;

  typedef struct packed {
    logic                       vld;
    logic                       last;
    logic signed [SAMPLE_W-1:0] smp;
  } lane_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_GEN
  } seq_state_t;

endpackage

// ===== rtl/lrs_lane.sv =====
// One channel's interpolation pipeline: a + round((b-a)*p/48000) in four stages.
// Depends on lrs_pkg. Advances only when the output side can take data.
`timescale 1ns / 1ps

module lrs_lane import lrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  iss_t      iss,
  input  lane_req_t req,
  output lane_out_t res
);

  localparam logic [YH_W-1:0] RECIP_V = YH_W'(RECIP);
  localparam logic [X_W-1:0]  HALF_X  = X_W'(HALF_RATE);
  localparam logic [X_W-1:0]  RATE_X  = X_W'(OUT_RATE);
  localparam logic [X_W-1:0]  RATE2_X = X_W'(2 * OUT_RATE);

  // Stage 1: magnitude of the difference times phase, plus half for rounding
  logic signed [D_W-1:0]      d;
  logic signed [D_W-1:0]      d_abs;
  logic [SAMPLE_W-1:0]        mag;
  logic [X_W-1:0]             x1_nxt;
  logic                       v1_r, l1_r, neg1_r;
  logic signed [SAMPLE_W-1:0] a1_r;
  logic [X_W-1:0]             x1_r;

  assign d      = $signed({req.b[SAMPLE_W-1], req.b}) - $signed({req.a[SAMPLE_W-1], req.a});
  assign d_abs  = d[D_W-1] ? -d : d;
  assign mag    = d_abs[SAMPLE_W-1:0];
  assign x1_nxt = {{PHS_W{1'b0}}, mag} * {{SAMPLE_W{1'b0}}, iss.phase} + HALF_X;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= iss.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r   <= iss.last;
      neg1_r <= d[D_W-1];
      a1_r   <= req.a;
      x1_r   <= x1_nxt;
    end
  end

  // Stage 2: quotient estimate by reciprocal, low by at most two
  logic [2*YH_W-1:0]          prod2;
  logic [YH_W-1:0]            qe2_nxt;
  logic                       v2_r, l2_r, neg2_r;
  logic signed [SAMPLE_W-1:0] a2_r;
  logic [X_W-1:0]             x2_r;
  logic [YH_W-1:0]            qe2_r;

  assign prod2   = {{YH_W{1'b0}}, x1_r[X_W-1:YH_SH]} * {{YH_W{1'b0}}, RECIP_V};
  assign qe2_nxt = prod2[2*YH_W-1:YH_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l2_r   <= l1_r;
      neg2_r <= neg1_r;
      a2_r   <= a1_r;
      x2_r   <= x1_r;
      qe2_r  <= qe2_nxt;
    end
  end

  // Stage 3: back-multiply the estimate
  logic [X_W-1:0]             t3_nxt;
  logic                       v3_r, l3_r, neg3_r;
  logic signed [SAMPLE_W-1:0] a3_r;
  logic [X_W-1:0]             x3_r, t3_r;
  logic [YH_W-1:0]            qe3_r;

  assign t3_nxt = {{(X_W-YH_W){1'b0}}, qe2_r} * RATE_X;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l3_r   <= l2_r;
      neg3_r <= neg2_r;
      a3_r   <= a2_r;
      x3_r   <= x2_r;
      t3_r   <= t3_nxt;
      qe3_r  <= qe2_r;
    end
  end

  // Stage 4: remainder correction and apply the step to a
  logic [X_W-1:0]             rem;
  logic [YH_W-1:0]            q;
  logic signed [YH_W:0]       a_ext;
  logic signed [YH_W:0]       q_ext;
  logic signed [YH_W:0]       sum4;
  lane_out_t                  out_nxt;
  logic                       out_vld_r;
  logic                       out_last_r;
  logic signed [SAMPLE_W-1:0] out_smp_r;

  assign rem   = x3_r - t3_r;
  assign q     = (rem >= RATE2_X) ? qe3_r + YH_W'(2) :
                 (rem >= RATE_X)  ? qe3_r + YH_W'(1) : qe3_r;
  assign a_ext = $signed({{(YH_W+1-SAMPLE_W){a3_r[SAMPLE_W-1]}}, a3_r});
  assign q_ext = $signed({1'b0, q});
  assign sum4  = neg3_r ? a_ext - q_ext : a_ext + q_ext;

  always_comb begin
    out_nxt.vld  = v3_r;
    out_nxt.last = l3_r;
    out_nxt.smp  = sum4[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= out_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last_r <= out_nxt.last;
      out_smp_r  <= out_nxt.smp;
    end
  end

  always_comb begin
    res.vld  = out_vld_r;
    res.last = out_last_r;
    res.smp  = out_smp_r;
  end

endmodule

// ===== rtl/lrs_seq.sv =====
// Frame sequencer: configuration registers, track state and phase accumulator.
// Depends on lrs_pkg. Issues one output per unstalled cycle to both lanes.
`timescale 1ns / 1ps

module lrs_seq import lrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  adv,
  output iss_t                  iss,
  output lane_req_t             req_l,
  output lane_req_t             req_r
);

  localparam logic [PH_W-1:0]     OUT_RATE_PH  = PH_W'(OUT_RATE);
  localparam logic [PHS_W-1:0]    OUT_RATE_PHS = PHS_W'(OUT_RATE);
  localparam logic [RATE_W-1:0]   RATE_LO      = RATE_W'(RATE_MIN);
  localparam logic [RATE_W-1:0]   RATE_HI      = RATE_W'(RATE_MAX);
  localparam logic signed [M_W-1:0]    OUT_RATE_M = M_W'(OUT_RATE);
  localparam logic signed [TAIL_W-1:0] OUT_RATE_T = TAIL_W'(OUT_RATE);

  // More outputs for this frame at phase p, margin m, count n
  function automatic logic gen_more(input logic lst, input logic [PH_W-1:0] p,
                                    input logic signed [M_W-1:0] m,
                                    input logic [CNT_W-1:0] n,
                                    input logic [RATE_W-1:0] rate);
    logic signed [M_W:0] m2;
    logic signed [M_W:0] rs;
    logic                cap_ok;
    m2     = {m, 1'b0};
    rs     = $signed({{(M_W+1-RATE_W){1'b0}}, rate});
    cap_ok = (n < CNT_W'(MAX_RESULTS));
    if (lst) begin
      gen_more = cap_ok && ((n == '0) || (m2 >= rs));
    end else begin
      gen_more = cap_ok && (p < OUT_RATE_PH);
    end
  endfunction

  seq_state_t                 state_r, state_nxt;
  logic [RATE_W-1:0]          rate_cfg_r;
  logic [CH_W-1:0]            chan_cfg_r;
  logic signed [SAMPLE_W-1:0] prev_l_r, prev_l_nxt, prev_r_r, prev_r_nxt;
  logic signed [SAMPLE_W-1:0] cur_l_r, cur_l_nxt, cur_r_r, cur_r_nxt;
  logic                       have_prev_r, have_prev_nxt, last_r, last_nxt;
  logic [PH_W-1:0]            phase_r, phase_nxt, p_r, p_nxt;
  logic signed [TAIL_W-1:0]   tail_r, tail_nxt;
  logic signed [M_W-1:0]      m_r, m_nxt;
  logic [CNT_W-1:0]           n_r, n_nxt;
  logic [RATE_W-1:0]          rate_r, rate_nxt;

  logic                       accept, mono;
  logic [RATE_W-1:0]          rate_clamp;
  logic signed [SAMPLE_W-1:0] cl, cr;
  logic                       p_lt, more, more_step, issue, finish;
  logic [PH_W:0]              p_sum;
  logic [PH_W-1:0]            p_step, p_fin;
  logic signed [M_W-1:0]      m_step, m_fin;
  logic [CNT_W-1:0]           n_step;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_cfg_r <= RATE_W'(RATE_RESET);
      chan_cfg_r <= CH_STEREO;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INPUT_RATE:    rate_cfg_r <= cfg_data;
        REG_CHANNEL_COUNT: chan_cfg_r <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side decode
  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign mono       = (chan_cfg_r == CH_MONO);
  assign rate_clamp = (rate_cfg_r < RATE_LO) ? RATE_LO :
                      (rate_cfg_r > RATE_HI) ? RATE_HI : rate_cfg_r;
  assign cl         = in_data.in_left;
  assign cr         = mono ? in_data.in_left : in_data.in_right;

  // Generation step and one-ahead lookahead
  assign p_lt      = (p_r < OUT_RATE_PH);
  assign p_sum     = {1'b0, p_r} + {{(PH_W+1-RATE_W){1'b0}}, rate_r};
  assign p_step    = p_lt ? p_sum[PH_W-1:0] : p_r;
  assign m_step    = m_r - $signed({{(M_W-RATE_W){1'b0}}, rate_r});
  assign n_step    = n_r + CNT_W'(1);
  assign more      = gen_more(last_r, p_r, m_r, n_r, rate_r);
  assign more_step = gen_more(last_r, p_step, m_step, n_step, rate_r);
  assign issue     = (state_r == ST_GEN) && more && adv;
  assign finish    = (state_r == ST_GEN) && (!more || (issue && !more_step));
  assign p_fin     = more ? p_step : p_r;
  assign m_fin     = more ? m_step : m_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (have_prev_r || in_data.in_last)) begin
          state_nxt = ST_GEN;
        end
      end
      ST_GEN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates and issue
  always_comb begin
    prev_l_nxt    = prev_l_r;
    prev_r_nxt    = prev_r_r;
    cur_l_nxt     = cur_l_r;
    cur_r_nxt     = cur_r_r;
    have_prev_nxt = have_prev_r;
    last_nxt      = last_r;
    phase_nxt     = phase_r;
    tail_nxt      = tail_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    rate_nxt      = rate_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cur_l_nxt = cl;
          cur_r_nxt = cr;
          last_nxt  = in_data.in_last;
          rate_nxt  = rate_clamp;
          n_nxt     = '0;
          if (!have_prev_r) begin
            // first frame of a track: becomes the previous frame
            prev_l_nxt = cl;
            prev_r_nxt = cr;
            phase_nxt  = '0;
            p_nxt      = '0;
            m_nxt      = OUT_RATE_M;
            if (!in_data.in_last) begin
              have_prev_nxt = 1'b1;
              tail_nxt      = OUT_RATE_T;
            end else begin
              tail_nxt = '0;
            end
          end else begin
            p_nxt = phase_r;
            m_nxt = $signed({{(M_W-TAIL_W){tail_r[TAIL_W-1]}}, tail_r}) + OUT_RATE_M;
          end
        end
      end
      ST_GEN: begin
        if (issue) begin
          p_nxt = p_step;
          m_nxt = m_step;
          n_nxt = n_step;
        end
        if (finish) begin
          if (last_r) begin
            // track done: back to reset state
            prev_l_nxt    = '0;
            prev_r_nxt    = '0;
            have_prev_nxt = 1'b0;
            phase_nxt     = '0;
            tail_nxt      = '0;
          end else begin
            prev_l_nxt = cur_l_r;
            prev_r_nxt = cur_r_r;
            phase_nxt  = (p_fin >= OUT_RATE_PH) ? p_fin - OUT_RATE_PH : '0;
            tail_nxt   = m_fin[TAIL_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    iss.vld   = issue;
    iss.last  = last_r && !more_step;
    iss.phase = p_lt ? p_r[PHS_W-1:0] : OUT_RATE_PHS;
    req_l.a   = prev_l_r;
    req_l.b   = cur_l_r;
    req_r.a   = prev_r_r;
    req_r.b   = cur_r_r;
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_prev_r <= 1'b0;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      phase_r     <= '0;
      tail_r      <= '0;
      last_r      <= 1'b0;
      p_r         <= '0;
      m_r         <= '0;
      n_r         <= '0;
      rate_r      <= RATE_W'(RATE_RESET);
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      prev_l_r    <= prev_l_nxt;
      prev_r_r    <= prev_r_nxt;
      phase_r     <= phase_nxt;
      tail_r      <= tail_nxt;
      last_r      <= last_nxt;
      p_r         <= p_nxt;
      m_r         <= m_nxt;
      n_r         <= n_nxt;
      rate_r      <= rate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_l_r <= cur_l_nxt;
    cur_r_r <= cur_r_nxt;
  end

endmodule

// ===== rtl/lrs_merge.sv =====
// Output stage: joins the left and right lane results into one stereo frame.
// Depends on lrs_pkg. Drives the pipeline advance from the output handshake.
`timescale 1ns / 1ps

module lrs_merge import lrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_out_t lane_l,
  input  lane_out_t lane_r,
  input  logic      out_ready,
  output logic      out_valid,
  output out_t      out_data,
  output logic      adv
);

  logic out_valid_r;
  out_t out_r, out_nxt;

  // Whole pipeline moves when the output register is empty or being drained
  assign adv = !out_valid_r || out_ready;

  always_comb begin
    out_nxt.out_left  = lane_l.smp;
    out_nxt.out_right = lane_r.smp;
    out_nxt.out_last  = lane_l.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= lane_l.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/linear_resample_to_48k_stereo.sv =====
// Top level of the linear-interpolation resampler to 48 kHz stereo.
// Depends on lrs_pkg, lrs_seq, lrs_lane and lrs_merge.
`timescale 1ns / 1ps

// Takes one mono or stereo frame per input transaction and produces 48 kHz
// stereo frames by linear interpolation between the previous and current frame,
// with an exact integer phase accumulator. The first frame of a track produces
// nothing unless it also ends the track; every later frame is taken and then
// yields none or up to 16 output frames, issued one per cycle while the output
// is not stalled. That pace is set by the single issue slot of
// the sequencer, which feeds a left and a right interpolation lane in lockstep.
// Each lane is a four-stage pipeline (multiply, reciprocal estimate,
// back-multiply, correct), followed by one output register in the merge;
// a stalled output holds the whole pipeline.
// Configuration is taken at any time on the cfg_ channel and must be written
// only while the block is idle.
module linear_resample_to_48k_stereo import lrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  iss_t      iss;
  lane_req_t req_l, req_r;
  lane_out_t lane_l, lane_r;
  logic      adv;

  // Sequencer
  lrs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .adv       (adv),
    .iss       (iss),
    .req_l     (req_l),
    .req_r     (req_r)
  );

  // Interpolation lanes
  lrs_lane u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .iss   (iss),
    .req   (req_l),
    .res   (lane_l)
  );

  lrs_lane u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .iss   (iss),
    .req   (req_r),
    .res   (lane_r)
  );

  // Stereo merge and output register
  lrs_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_l    (lane_l),
    .lane_r    (lane_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .adv       (adv)
  );

  // Lanes stay in lockstep
  assert property (@(posedge clk) disable iff (!rst_n)
    (lane_l.vld == lane_r.vld) && (!lane_l.vld || (lane_l.last == lane_r.last)))
    else $error("interpolation lanes out of step");

  // Nothing is issued into a stalled pipeline
  assert property (@(posedge clk) disable iff (!rst_n) iss.vld |-> adv)
    else $error("issue while pipeline stalled");

  // Outputs are only issued while no new frame can be taken
  assert property (@(posedge clk) disable iff (!rst_n) iss.vld |-> !in_ready)
    else $error("issue while input channel open");

endmodule
